### rtl/pol_pkg.sv
`default_nettype none

package pol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 16;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_PREPEND  = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_POP_TAIL = 3'd3,
    MODE_POP_HEAD = 3'd4,
    MODE_REMOVE   = 3'd5,
    MODE_DUMP     = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [COUNT_W-1:0] idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/pol_if.sv
`default_nettype none

interface pol_in_if;
  import pol_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pol_out_if;
  import pol_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] item_value;
  logic [COUNT_W-1:0]       entry_count;
  logic                     last;

  modport source (output valid, status, item_value, entry_count, last, input ready);
  modport sink   (input valid, status, item_value, entry_count, last, output ready);
endinterface

`default_nettype wire

### rtl/pol_cell.sv
`default_nettype none

module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic signed [DATA_W-1:0] right_data,
  input  wire logic signed [DATA_W-1:0] wrap_data,
  output logic signed [DATA_W-1:0]      data
);

  localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX > cmd.idx) begin
          data_nxt = left_data;
        end else if (MY_IDX == cmd.idx) begin
          data_nxt = value;
        end
      end
      CELL_REM: begin
        if (MY_IDX >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CELL_ROT: begin
        // idx holds the last occupied slot
        if (MY_IDX == cmd.idx) begin
          data_nxt = wrap_data;
        end else if (MY_IDX < cmd.idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

### rtl/positional_ordered_list.sv
// positional_ordered_list: bounded ordered list held in a row of shifting cells
// append, prepend, insert, both pops, remove and no-op give their single item in the cycle after
// acceptance; one command per cycle while the output is taken and no dump is in progress
// dump: acceptance sets dump_r, then one item per cycle per stored entry while output is taken,
// read by the single head-cell read port as the row rotates; next command after the last
// reset: synchronous active-low rst_n empties the list and the output; entries are not cleared
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pol_in_if.sink    in_ch,
  pol_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dump_r, dump_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic signed [DATA_W-1:0] item_r, item_nxt;
  logic [COUNT_W-1:0]       cnt_out_r, cnt_out_nxt;
  logic                     last_r, last_nxt;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  logic             out_free;
  logic             accept;
  logic [POS_W-1:0] cnt16;
  logic             pos_past;
  mode_t            mode;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !dump_r && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt16       = POS_W'(count_r);
  assign pos_past    = in_ch.position >= cnt16;
  assign mode        = mode_t'(in_ch.mode);

  always_comb begin
    count_nxt     = count_r;
    dump_nxt      = dump_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    item_nxt      = item_r;
    cnt_out_nxt   = cnt_out_r;
    last_nxt      = last_r;
    cmd.op        = CELL_HOLD;
    cmd.idx       = '0;

    if (dump_r && out_free) begin
      cmd.op        = CELL_ROT;
      cmd.idx       = COUNT_W'(count_r - ONE_C);
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      item_nxt      = cell_q[0];
      cnt_out_nxt   = COUNT_W'(count_r);
      last_nxt      = (rem_r == ONE_C);
      rem_nxt       = rem_r - ONE_C;
      dump_nxt      = (rem_r != ONE_C);
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      item_nxt      = '0;
      last_nxt      = 1'b1;
      case (mode)
        MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
          if (count_r == CAP_C) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op = CELL_INS;
            if (mode == MODE_APPEND) begin
              cmd.idx = COUNT_W'(count_r);
            end else if (mode == MODE_PREPEND) begin
              cmd.idx = '0;
            end else if (pos_past) begin
              cmd.idx = COUNT_W'(count_r);
            end else begin
              cmd.idx = COUNT_W'(in_ch.position);
            end
            count_nxt = count_r + ONE_C;
          end
        end
        MODE_POP_TAIL, MODE_POP_HEAD, MODE_REMOVE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.op = CELL_REM;
            if (mode == MODE_POP_HEAD) begin
              cmd.idx = '0;
            end else if (mode == MODE_POP_TAIL || pos_past) begin
              cmd.idx = COUNT_W'(count_r - ONE_C);
            end else begin
              cmd.idx = COUNT_W'(in_ch.position);
            end
            count_nxt = count_r - ONE_C;
          end
        end
        MODE_DUMP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = out_valid_r && !out_ch.ready;
            status_nxt    = status_r;
            item_nxt      = item_r;
            last_nxt      = last_r;
            dump_nxt      = 1'b1;
            rem_nxt       = count_r;
          end
        end
        default: status_nxt = ST_OK;
      endcase
      if (!(mode == MODE_DUMP && count_r != '0)) begin
        cnt_out_nxt = COUNT_W'(count_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dump_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dump_r      <= dump_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    item_r    <= item_nxt;
    cnt_out_r <= cnt_out_nxt;
    last_r    <= last_nxt;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[k+1];
    end
    pol_cell #(
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .value      (in_ch.value),
      .left_data  (left_d),
      .right_data (right_d),
      .wrap_data  (cell_q[0]),
      .data       (cell_q[k])
    );
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.item_value  = item_r;
  assign out_ch.entry_count = cnt_out_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire
